// ===== rtl/core/lpm_pkg.sv =====
`default_nettype none

package lpm_pkg;

    localparam int IN_IDX_W  = 5;
    localparam int IP_W      = 32;
    localparam int PORT_W    = 2;
    localparam int S_TDATA_W = 136;
    localparam int M_TDATA_W = 40;

    typedef struct packed {
        logic              valid;
        logic [PORT_W-1:0] port;
        logic [IP_W-1:0]   gateway;
        logic [IP_W-1:0]   mask;
        logic [IP_W-1:0]   dest;
    } route_entry_t;

    typedef struct packed {
        logic load_item;
        logic mem_clear;
        logic rd_en;
        logic cnt_rst;
        logic cnt_inc;
        logic out_load;
    } lpm_cmd_t;

    typedef struct packed {
        logic cnt_last;
        logic in_lookup;
        logic out_free;
    } lpm_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/ipv4_longest_prefix_route_lookup.sv =====
`default_nettype none

// Longest-prefix IPv4 route table. Each input item is either a table write
// (s_tuser = 0) or a lookup (s_tuser = 1); every item returns one result item.
// A lookup reads the route RAM one entry per cycle over all TABLE_ENTRIES
// slots. After reset a clearing pass over every slot zeroes the valid
// flags while s_tready stays low. The result sits in an output register,
// so the next item is taken while the previous result waits.
module ipv4_longest_prefix_route_lookup
    import lpm_pkg::*;
#(
    parameter int TABLE_ENTRIES = 32,
    parameter int NUM_PORTS     = 4
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // entry_index, entry_dest, entry_mask, entry_gateway, entry_port,
    // entry_valid, lookup_addr
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // cmd
    input  wire logic [0:0]           s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // route_index, next_hop, out_port, zero pad
    output logic [M_TDATA_W-1:0]      m_tdata,
    // hit
    output logic [0:0]                m_tuser
);

    lpm_cmd_t  cmd;
    lpm_stat_t stat;

    lpm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lpm_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .NUM_PORTS     (NUM_PORTS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

`ifndef SYNTH
    a_load_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> stat.out_free)
        else $error("result loaded over a pending result");

    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.mem_clear || cmd.rd_en) |-> !s_tready)
        else $error("input ready during clear or scan");

    a_miss_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
        else $error("miss result carries nonzero fields");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/lpm_ctrl.sv =====
`default_nettype none

module lpm_ctrl
    import lpm_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_tvalid,
    output logic           s_tready,
    input  wire lpm_stat_t stat,
    output lpm_cmd_t       cmd
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.mem_clear = 1'b1;
                cmd.cnt_inc   = 1'b1;
                if (stat.cnt_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_item = 1'b1;
                    cmd.cnt_rst   = 1'b1;
                    state_next    = stat.in_lookup ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN: begin
                cmd.rd_en   = 1'b1;
                cmd.cnt_inc = 1'b1;
                if (stat.cnt_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/lpm_datapath.sv =====
`default_nettype none

module lpm_datapath
    import lpm_pkg::*;
#(
    parameter int TABLE_ENTRIES = 32,
    parameter int NUM_PORTS     = 4
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic [0:0]           s_tuser,
    input  wire lpm_cmd_t             cmd,
    output lpm_stat_t                 stat,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,
    output logic [0:0]                m_tuser
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [IP_W-1:0]   DEPTH_CMP = IP_W'(TABLE_ENTRIES);
    localparam logic [6:0]        PORTS_CMP = 7'(NUM_PORTS);
    localparam logic [PORT_W-1:0] PORT_MAX  = PORT_W'(NUM_PORTS - 1);

    logic [IN_IDX_W-1:0] in_index;
    logic [IP_W-1:0]     in_dest;
    logic [IP_W-1:0]     in_mask;
    logic [IP_W-1:0]     in_gateway;
    logic [PORT_W-1:0]   in_port;
    logic                in_valid;
    logic [IP_W-1:0]     in_addr;

    assign in_index   = s_tdata[4:0];
    assign in_dest    = s_tdata[36:5];
    assign in_mask    = s_tdata[68:37];
    assign in_gateway = s_tdata[100:69];
    assign in_port    = s_tdata[102:101];
    assign in_valid   = s_tdata[103];
    assign in_addr    = s_tdata[135:104];

    route_entry_t      mem [TABLE_ENTRIES];
    route_entry_t      wr_data;
    route_entry_t      rd_data_reg;
    logic [IDX_W-1:0]  wr_addr;
    logic              mem_we;
    logic              slot_ok;
    logic [PORT_W-1:0] port_sat;

    logic [IDX_W-1:0]  cnt_reg;
    logic [IDX_W-1:0]  rd_idx_reg;
    logic              cmp_en_reg;
    logic [IP_W-1:0]   addr_reg;

    logic              found_reg;
    logic [IP_W-1:0]   best_mask_reg;
    logic [IDX_W-1:0]  best_idx_reg;
    logic [IP_W-1:0]   best_gw_reg;
    logic [PORT_W-1:0] best_port_reg;
    logic              take;

    logic                out_valid_reg;
    logic                out_hit_reg;
    logic [IN_IDX_W-1:0] out_idx_reg;
    logic [IP_W-1:0]     out_gw_reg;
    logic [PORT_W-1:0]   out_port_reg;

    // write side: clearing pass or a table write item
    assign slot_ok  = {{(IP_W-IN_IDX_W){1'b0}}, in_index} < DEPTH_CMP;
    assign port_sat = ({5'd0, in_port} >= PORTS_CMP) ? PORT_MAX : in_port;
    assign mem_we   = cmd.mem_clear || (cmd.load_item && !s_tuser[0] && slot_ok);
    assign wr_addr  = cmd.mem_clear ? cnt_reg : IDX_W'(in_index);

    always_comb begin
        wr_data = '0;
        if (!cmd.mem_clear) begin
            wr_data.valid   = in_valid;
            wr_data.port    = port_sat;
            wr_data.gateway = in_gateway;
            wr_data.mask    = in_mask;
            wr_data.dest    = in_dest;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            rd_data_reg <= mem[cnt_reg];
            rd_idx_reg  <= cnt_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= '0;
            cmp_en_reg <= 1'b0;
        end else begin
            cmp_en_reg <= cmd.rd_en;
            if (cmd.cnt_rst) begin
                cnt_reg <= '0;
            end else if (cmd.cnt_inc) begin
                cnt_reg <= (cnt_reg == LAST_IDX) ? '0 : cnt_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            addr_reg <= in_addr;
        end
    end

    // strictly larger mask wins, so the lowest slot keeps ties
    assign take = cmp_en_reg && rd_data_reg.valid
                  && (((rd_data_reg.dest ^ addr_reg) & rd_data_reg.mask) == '0)
                  && (!found_reg || (rd_data_reg.mask > best_mask_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else if (cmd.load_item) begin
            found_reg <= 1'b0;
        end else if (take) begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            best_mask_reg <= '0;
            best_idx_reg  <= '0;
            best_gw_reg   <= '0;
            best_port_reg <= '0;
        end else if (take) begin
            best_mask_reg <= rd_data_reg.mask;
            best_idx_reg  <= rd_idx_reg;
            best_gw_reg   <= rd_data_reg.gateway;
            best_port_reg <= rd_data_reg.port;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_hit_reg  <= found_reg;
            out_idx_reg  <= IN_IDX_W'(best_idx_reg);
            out_gw_reg   <= best_gw_reg;
            out_port_reg <= best_port_reg;
        end
    end

    assign stat.cnt_last  = (cnt_reg == LAST_IDX);
    assign stat.in_lookup = s_tuser[0];
    assign stat.out_free  = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_hit_reg;
    assign m_tdata  = {1'b0, out_port_reg, out_gw_reg, out_idx_reg};

endmodule

`default_nettype wire
